### hdl/ptbl_pkg.sv
// Package for the polar table bilinear lookup unit.
// Holds word types, status and register codes, and controller/datapath command types.
// No dependencies.
`default_nettype none
package ptbl_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 16;

  localparam int VAL_W   = 14;  // cell and speed width
  localparam int NUM_W   = 44;  // interpolation numerator
  localparam int DEN_W   = 28;  // interpolation denominator
  localparam int HNUM_W  = 30;  // heel numerator
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 11;

  localparam logic [VAL_W-1:0] SPEED_SAT = 14'd16383;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_CLAMPED = 2'd2;
  localparam logic [1:0] ST_MAXZERO = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COLS  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MINW  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_HEEL  = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  row_index;
    logic [3:0]  col_index;
    logic [13:0] entry_value;
    logic [11:0] query_angle;
    logic [10:0] query_wind;
    logic [8:0]  ratio;
  } in_word_t;

  typedef struct packed {
    logic [13:0] speed;
    logic [13:0] scaled_speed;
    logic [13:0] heel;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic load;        // capture accepted word
    logic axis;        // 0 angle axis (rows), 1 wind axis (cols)
    logic scan_init;
    logic scan_issue;
    logic scan_proc;
    logic scan_fin;
    logic corner_rd;
    logic corner_m1;
    logic corner_m2;
    logic den_calc;
    logic div_spd;
    logic spd_take;
    logic heel_prep;
    logic div_heel;
    logic heel_take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_write;
    logic in_zero;
    logic scan_last;
    logic corner_last;
    logic div_busy;
    logic max_zero;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### hdl/polar_table_bilinear_lookup_unit.sv
// Top level of the polar table bilinear lookup unit.
// Depends on ptbl_pkg, ptbl_controller, ptbl_datapath.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data) takes one word per item: a table
//    write (opcode write) or a speed query. Every word yields exactly one
//    result word on the out channel (out_valid/out_ready/out_data).
//  - cfg channel writes rows_in_use, cols_in_use, min_wind, heel_limit by
//    index; cfg_ready is always high. Write config only while idle.
//  - One item at a time. A table write or a zero-angle/zero-wind query
//    goes from accept straight to the finish state. A full query scans
//    each axis with one RAM read per cycle, then reads each table corner
//    and scales it by its row and column weights, then makes two passes
//    of the shared 44-step restoring divider (speed, then heel). A query
//    with zero max speed skips the heel pass.
//  - Results sit in an output register; a new word is accepted while it
//    waits, but the next result is held until the receiver takes the
//    previous one.
//  - rst (synchronous) clears the controller, the output valid and max speed,
//    and resets the config registers to defaults. The table RAM is not cleared;
//    reading a never-written cell gives an undefined result.
`default_nettype none
module polar_table_bilinear_lookup_unit #(
  parameter int MAX_ROWS = ptbl_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ptbl_pkg::MAX_COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ptbl_pkg::in_word_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ptbl_pkg::out_word_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ptbl_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [ptbl_pkg::CFG_DW-1:0] cfg_data
);
  import ptbl_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  // sequencer: only state, emits one command set per cycle
  ptbl_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // everything that holds data: config, table, search, math, output reg
  ptbl_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_accept (in_valid && in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

### hdl/ptbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ptbl_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hdl/ptbl_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ptbl_pkg.
`default_nettype none
module ptbl_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ptbl_pkg::NUM_W-1:0] num,
  input  wire logic [ptbl_pkg::DEN_W-1:0] den,
  output logic                           busy,
  output logic      [ptbl_pkg::NUM_W-1:0] quot
);
  import ptbl_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] d;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;

  assign trial = {rem, quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      d    <= den;
      rem  <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem  <= DEN_W'(trial - {1'b0, d});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### hdl/ptbl_datapath.sv
// Datapath: config registers, table RAM, axis scan, corner accumulation, divider, result.
// Depends on ptbl_pkg, ptbl_ram, ptbl_divider.
`default_nettype none
module ptbl_datapath #(
  parameter int MAX_ROWS = ptbl_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ptbl_pkg::MAX_COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ptbl_pkg::cmd_t              cmd,
  output ptbl_pkg::stat_t                  st,
  input  wire logic                        in_accept,
  input  wire ptbl_pkg::in_word_t          in_data,
  input  wire logic                        cfg_valid,
  input  wire logic [ptbl_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [ptbl_pkg::CFG_DW-1:0] cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ptbl_pkg::out_word_t              out_data
);
  import ptbl_pkg::*;

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 1);
  localparam int SW  = (NRW > NCW) ? NRW : NCW;

  // configuration
  logic [5:0]  rows_in_use;
  logic [4:0]  cols_in_use;
  logic [10:0] min_wind;
  logic [5:0]  heel_limit;
  logic [VAL_W-1:0] max_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 6'd2;
      cols_in_use <= 5'd2;
      min_wind    <= 11'd64;
      heel_limit  <= 6'd30;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data[5:0];
        REG_COLS: cols_in_use <= cfg_data[4:0];
        REG_MINW: min_wind    <= cfg_data;
        REG_HEEL: heel_limit  <= cfg_data[5:0];
        default:  ;
      endcase
    end
  end

  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  always_comb begin
    if (rows_in_use < 6'd2)              nr = NRW'(2);
    else if (32'(rows_in_use) > MAX_ROWS) nr = NRW'(MAX_ROWS);
    else                                  nr = NRW'(rows_in_use);
    if (cols_in_use < 5'd2)              nc = NCW'(2);
    else if (32'(cols_in_use) > MAX_COLS) nc = NCW'(MAX_COLS);
    else                                  nc = NCW'(cols_in_use);
  end

  // table writes happen on the accept edge
  logic          wr_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  assign wr_ok   = (32'(in_data.row_index) < MAX_ROWS) && (32'(in_data.col_index) < MAX_COLS);
  assign wr_en   = in_accept && (in_data.opcode == OP_WRITE) && wr_ok;
  assign wr_addr = AW'(AW'(in_data.row_index) * AW'(MAX_COLS)) + AW'(in_data.col_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= '0;
    end else if (wr_en && in_data.row_index != 5'd0 && in_data.col_index != 4'd0
                 && in_data.entry_value > max_speed) begin
      max_speed <= in_data.entry_value;
    end
  end

  // held query
  logic [11:0] q_angle;
  logic [10:0] q_wind;
  logic [8:0]  q_ratio;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_angle <= in_data.query_angle;
      q_wind  <= (in_data.query_wind < min_wind) ? min_wind : in_data.query_wind;
      q_ratio <= in_data.ratio;
    end
  end

  // axis scan
  logic [SW-1:0]    idx, pend_idx, found, n_axis;
  logic             pend;
  logic [VAL_W-1:0] alo, ahi, q_axis, rd_data;
  logic [AW-1:0]    rd_addr;

  assign n_axis = cmd.axis ? SW'(nc) : SW'(nr);
  assign q_axis = cmd.axis ? VAL_W'(q_wind) : VAL_W'(q_angle);

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx   <= SW'(1);
      pend  <= 1'b0;
      found <= '0;
    end else begin
      if (cmd.scan_issue) begin
        idx      <= idx + SW'(1);
        pend_idx <= idx;
      end
      pend <= cmd.scan_issue;
      if (cmd.scan_proc && pend) begin
        if (rd_data <= q_axis) begin
          found <= pend_idx;
          alo   <= rd_data;
        end else if (pend_idx == found + SW'(1)) begin
          ahi <= rd_data;
        end
      end
    end
  end

  // bracket of the finished scan
  logic [SW-1:0]    f_lo, f_hi;
  logic [VAL_W-1:0] f_off, f_span;
  logic             f_clamp;
  always_comb begin
    if (found == '0) begin
      f_lo = SW'(1); f_hi = SW'(1); f_off = '0; f_span = VAL_W'(1); f_clamp = 1'b1;
    end else if (found == n_axis - SW'(1)) begin
      f_lo = found; f_hi = found; f_off = '0; f_span = VAL_W'(1); f_clamp = (alo != q_axis);
    end else begin
      f_lo = found; f_hi = found + SW'(1);
      f_off = q_axis - alo; f_span = ahi - alo; f_clamp = 1'b0;
    end
  end

  logic [RIW-1:0]   r0, r1;
  logic [CIW-1:0]   c0, c1;
  logic [VAL_W-1:0] wr0, wr1, wc0, wc1, da, dw;
  logic             clamp;
  always_ff @(posedge clk) begin
    if (cmd.scan_fin) begin
      if (!cmd.axis) begin
        r0 <= RIW'(f_lo); r1 <= RIW'(f_hi);
        wr0 <= f_span - f_off; wr1 <= f_off; da <= f_span;
        clamp <= f_clamp;
      end else begin
        c0 <= CIW'(f_lo); c1 <= CIW'(f_hi);
        wc0 <= f_span - f_off; wc1 <= f_off; dw <= f_span;
        clamp <= clamp | f_clamp;
      end
    end
  end

  // corners: k[0] picks the upper row, k[1] the upper column
  logic [1:0]       k;
  logic [27:0]      p1;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] den;
  always_ff @(posedge clk) begin
    if (cmd.scan_fin && cmd.axis) begin
      k   <= '0;
      acc <= '0;
    end
    if (cmd.corner_m1) begin
      p1 <= 28'(rd_data) * 28'(k[0] ? wr1 : wr0);
    end
    if (cmd.corner_m2) begin
      acc <= acc + NUM_W'(42'(p1) * 42'(k[1] ? wc1 : wc0));
      k   <= k + 2'd1;
    end
    if (cmd.den_calc) begin
      den <= DEN_W'(DEN_W'(da) * DEN_W'(dw));
    end
  end

  always_comb begin
    if (cmd.corner_rd) begin
      rd_addr = AW'(AW'(k[0] ? r1 : r0) * AW'(MAX_COLS)) + AW'(k[1] ? c1 : c0);
    end else if (cmd.axis) begin
      rd_addr = AW'(idx);
    end else begin
      rd_addr = AW'(AW'(idx) * AW'(MAX_COLS));
    end
  end

  ptbl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.entry_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared divider
  logic             div_start, div_busy;
  logic [NUM_W-1:0] div_num, quot;
  logic [DEN_W-1:0] div_den;
  logic [HNUM_W-1:0] hnum;

  assign div_start = cmd.div_spd | cmd.div_heel;
  assign div_num   = cmd.div_heel ? NUM_W'(hnum) : acc + NUM_W'(den >> 1);
  assign div_den   = cmd.div_heel ? DEN_W'(max_speed) : den;

  ptbl_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  // result
  logic [VAL_W-1:0] res_speed, res_scaled, res_heel, spd_sat;
  logic [1:0]       res_status;
  logic [22:0]      scaled_full;
  logic [19:0]      prod1;
  logic [VAL_W:0]   scaled_sh;

  assign spd_sat     = (quot > NUM_W'(SPEED_SAT)) ? SPEED_SAT : quot[VAL_W-1:0];
  assign scaled_full = 23'(spd_sat) * 23'(q_ratio) + 23'd128;
  assign scaled_sh   = scaled_full[22:8];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_speed  <= '0;
      res_scaled <= '0;
      res_heel   <= '0;
      res_status <= (in_data.opcode == OP_QUERY && st.in_zero) ? ST_ZERO : ST_OK;
    end
    if (cmd.spd_take) begin
      res_speed  <= spd_sat;
      res_scaled <= (scaled_sh > (VAL_W+1)'(SPEED_SAT)) ? SPEED_SAT : scaled_sh[VAL_W-1:0];
      prod1      <= 20'(spd_sat) * 20'(heel_limit);
      res_status <= (max_speed == '0) ? ST_MAXZERO : (clamp ? ST_CLAMPED : ST_OK);
    end
    if (cmd.heel_prep) begin
      hnum <= HNUM_W'(HNUM_W'(prod1) * HNUM_W'(q_ratio)) + HNUM_W'(max_speed >> 1);
    end
    if (cmd.heel_take) begin
      res_heel <= spd_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= '{speed: res_speed, scaled_speed: res_scaled,
                    heel: res_heel, status: res_status};
    end
  end

  assign st.in_write    = (in_data.opcode == OP_WRITE);
  assign st.in_zero     = (in_data.query_angle == 12'd0) || (in_data.query_wind == 11'd0);
  assign st.scan_last   = (idx == n_axis - SW'(1));
  assign st.corner_last = (k == 2'd3);
  assign st.div_busy    = div_busy;
  assign st.max_zero    = (max_speed == '0);
  assign st.out_free    = !out_valid || out_ready;
endmodule
`default_nettype wire

### hdl/ptbl_controller.sv
// Sequencer for the lookup unit: steps the datapath through scan, corners and divides.
// Depends on ptbl_pkg.
`default_nettype none
module ptbl_controller (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ptbl_pkg::stat_t st,
  output ptbl_pkg::cmd_t       cmd
);
  import ptbl_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RINIT  = 5'd1;
  localparam logic [4:0] S_RSCAN  = 5'd2;
  localparam logic [4:0] S_RDRAIN = 5'd3;
  localparam logic [4:0] S_RFIN   = 5'd4;
  localparam logic [4:0] S_CINIT  = 5'd5;
  localparam logic [4:0] S_CSCAN  = 5'd6;
  localparam logic [4:0] S_CDRAIN = 5'd7;
  localparam logic [4:0] S_CFIN   = 5'd8;
  localparam logic [4:0] S_CRD    = 5'd9;
  localparam logic [4:0] S_CM1    = 5'd10;
  localparam logic [4:0] S_CM2    = 5'd11;
  localparam logic [4:0] S_DEN    = 5'd12;
  localparam logic [4:0] S_DSTART = 5'd13;
  localparam logic [4:0] S_DWAIT  = 5'd14;
  localparam logic [4:0] S_SPD    = 5'd15;
  localparam logic [4:0] S_HPREP  = 5'd16;
  localparam logic [4:0] S_HSTART = 5'd17;
  localparam logic [4:0] S_HWAIT  = 5'd18;
  localparam logic [4:0] S_HTAKE  = 5'd19;
  localparam logic [4:0] S_FIN    = 5'd20;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (st.in_write || st.in_zero) ? S_FIN : S_RINIT;
        end
      end
      S_RINIT:  begin cmd.scan_init = 1'b1; state_next = S_RSCAN; end
      S_RSCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.scan_proc  = 1'b1;
        if (st.scan_last) state_next = S_RDRAIN;
      end
      S_RDRAIN: begin cmd.scan_proc = 1'b1; state_next = S_RFIN; end
      S_RFIN:   begin cmd.scan_fin = 1'b1; state_next = S_CINIT; end
      S_CINIT:  begin cmd.axis = 1'b1; cmd.scan_init = 1'b1; state_next = S_CSCAN; end
      S_CSCAN: begin
        cmd.axis       = 1'b1;
        cmd.scan_issue = 1'b1;
        cmd.scan_proc  = 1'b1;
        if (st.scan_last) state_next = S_CDRAIN;
      end
      S_CDRAIN: begin cmd.axis = 1'b1; cmd.scan_proc = 1'b1; state_next = S_CFIN; end
      S_CFIN:   begin cmd.axis = 1'b1; cmd.scan_fin = 1'b1; state_next = S_CRD; end
      S_CRD:    begin cmd.corner_rd = 1'b1; state_next = S_CM1; end
      S_CM1:    begin cmd.corner_m1 = 1'b1; state_next = S_CM2; end
      S_CM2: begin
        cmd.corner_m2 = 1'b1;
        state_next    = st.corner_last ? S_DEN : S_CRD;
      end
      S_DEN:    begin cmd.den_calc = 1'b1; state_next = S_DSTART; end
      S_DSTART: begin cmd.div_spd = 1'b1; state_next = S_DWAIT; end
      S_DWAIT:  if (!st.div_busy) state_next = S_SPD;
      S_SPD: begin
        cmd.spd_take = 1'b1;
        state_next   = st.max_zero ? S_FIN : S_HPREP;
      end
      S_HPREP:  begin cmd.heel_prep = 1'b1; state_next = S_HSTART; end
      S_HSTART: begin cmd.div_heel = 1'b1; state_next = S_HWAIT; end
      S_HWAIT:  if (!st.div_busy) state_next = S_HTAKE;
      S_HTAKE:  begin cmd.heel_take = 1'b1; state_next = S_FIN; end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/ptbl_checker.sv
// Port-level checks for the lookup unit, bound to the top level.
// Depends on ptbl_pkg and polar_table_bilinear_lookup_unit.
`default_nettype none
module ptbl_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire ptbl_pkg::out_word_t         out_data
);
  import ptbl_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: busy right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  // zero-input results are all zero
  a_zero_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_ZERO |->
      out_data.speed == '0 && out_data.scaled_speed == '0 && out_data.heel == '0)
    else $error("zero-input result not zero");

  // a zero max speed gives no heel
  a_maxz_heel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_MAXZERO |-> out_data.heel == '0)
    else $error("heel nonzero with zero max speed");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");
endmodule

bind polar_table_bilinear_lookup_unit ptbl_checker u_ptbl_checker (.*);
`default_nettype wire
